### src/html_text_line_filter_top_assert.svh
// Assertion macros shared by the text line filter modules.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef HTML_TEXT_LINE_FILTER_TOP_ASSERT_SVH
`define HTML_TEXT_LINE_FILTER_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define HLF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define HLF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/hlf_pkg.sv
// Package for the text line filter: character codes, result kinds, register
// indexes and the payload and descriptor types. No dependencies.
`timescale 1ns / 1ps

package hlf_pkg;

  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_SP  = 8'h20;
  localparam logic [7:0] CH_LT  = 8'h3C;
  localparam logic [7:0] CH_GT  = 8'h3E;

  typedef enum logic [1:0] {
    KIND_CHAR = 2'd0,
    KIND_EOL  = 2'd1,
    KIND_EOD  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    REG_MAX_LINES   = 2'd0,
    REG_Y_START     = 2'd1,
    REG_LINE_HEIGHT = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [7:0] char_in;
    logic       doc_end;
  } in_payload_t;

  typedef struct packed {
    kind_t              kind;
    logic [7:0]         char_out;
    logic signed [15:0] line_y;
    logic [7:0]         lines_done;
    logic               run_last;
  } out_payload_t;

  typedef struct packed {
    logic        sp;
    logic        ch_en;
    logic [7:0]  ch;
    logic        eol;
    logic        eod;
    logic [15:0] y_a;
    logic [7:0]  lt_a;
    logic [15:0] y_e;
    logic [7:0]  lt_e;
  } desc_t;

endpackage

### src/hlf_if.sv
// Valid/ready channel interfaces for input bytes and result transactions.
// Depends on hlf_pkg for the payload types.
`timescale 1ns / 1ps

interface hlf_in_if;
  logic                valid;
  logic                ready;
  hlf_pkg::in_payload_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface hlf_out_if;
  logic                 valid;
  logic                 ready;
  hlf_pkg::out_payload_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

### src/hlf_front.sv
// Front end: accepts input bytes, tracks line and document state, and turns
// each byte into a result descriptor. Depends on hlf_pkg and hlf_in_if.
`timescale 1ns / 1ps

module hlf_front #(
  parameter int LINE_BUFFER = 96
) (
  input  logic                clk,
  input  logic                rst_n,
  hlf_in_if.sink              in_if,
  input  logic [7:0]          max_lines,
  input  logic [15:0]         y_start,
  input  logic [15:0]         line_height,
  input  logic                q_full,
  output logic                push,
  output hlf_pkg::desc_t      push_desc
);

  localparam int RAW_W = $clog2(LINE_BUFFER);
  localparam logic [RAW_W-1:0] RAW_LIM = RAW_W'(LINE_BUFFER - 1);

  logic             busy_r, busy_nxt;
  logic             in_tag_r, in_tag_nxt;
  logic             after_sp_r, after_sp_nxt;
  logic             pend_sp_r, pend_sp_nxt;
  logic             open_r, open_nxt;
  logic             has_text_r, has_text_nxt;
  logic [RAW_W-1:0] raw_r, raw_nxt;
  logic [7:0]       lt_r, lt_nxt;
  logic [15:0]      y_r, y_nxt;
  logic             stopped_r, stopped_nxt;
  logic             accept;
  logic             do_close;
  logic [7:0]       c;
  logic             is_ws;
  hlf_pkg::desc_t   d;

  assign in_if.ready = !q_full;
  assign accept      = in_if.valid && !q_full;
  assign c           = in_if.payload.char_in;
  assign is_ws       = (c == hlf_pkg::CH_SP) ||
                       ((c >= hlf_pkg::CH_TAB) && (c <= hlf_pkg::CH_CR));

  always_comb begin
    busy_nxt     = 1'b1;
    in_tag_nxt   = in_tag_r;
    after_sp_nxt = after_sp_r;
    pend_sp_nxt  = pend_sp_r;
    open_nxt     = open_r;
    has_text_nxt = has_text_r;
    raw_nxt      = raw_r;
    lt_nxt       = lt_r;
    y_nxt        = y_r;
    stopped_nxt  = stopped_r;
    do_close     = 1'b0;
    d            = '0;
    if (!busy_r) begin
      y_nxt        = y_start;
      lt_nxt       = '0;
      stopped_nxt  = 1'b0;
      in_tag_nxt   = 1'b0;
      after_sp_nxt = 1'b1;
      pend_sp_nxt  = 1'b0;
      open_nxt     = 1'b0;
      has_text_nxt = 1'b0;
      raw_nxt      = '0;
    end
    if (!stopped_nxt && (c != hlf_pkg::CH_NUL)) begin
      if ((c == hlf_pkg::CH_CR) || (c == hlf_pkg::CH_LF)) begin
        do_close = open_nxt;
      end else begin
        if (!open_nxt) begin
          if (lt_nxt >= max_lines) begin
            stopped_nxt = 1'b1;
          end else begin
            in_tag_nxt   = 1'b0;
            after_sp_nxt = 1'b1;
            pend_sp_nxt  = 1'b0;
            has_text_nxt = 1'b0;
            raw_nxt      = '0;
            open_nxt     = 1'b1;
          end
        end
        if (open_nxt) begin
          raw_nxt = raw_nxt + 1'b1;
          if (c == hlf_pkg::CH_LT) begin
            in_tag_nxt = 1'b1;
          end else if (c == hlf_pkg::CH_GT) begin
            in_tag_nxt = 1'b0;
          end else if (!in_tag_nxt) begin
            if (is_ws) begin
              if (!after_sp_nxt) begin
                pend_sp_nxt  = 1'b1;
                after_sp_nxt = 1'b1;
              end
            end else begin
              d.sp         = pend_sp_nxt;
              d.ch_en      = 1'b1;
              d.ch         = c;
              pend_sp_nxt  = 1'b0;
              after_sp_nxt = 1'b0;
              has_text_nxt = 1'b1;
            end
          end
          if (raw_nxt >= RAW_LIM) begin
            do_close = 1'b1;
          end
        end
      end
    end
    if (in_if.payload.doc_end && !stopped_nxt && open_nxt) begin
      do_close = 1'b1;
    end
    d.y_a  = y_nxt;
    d.lt_a = lt_nxt;
    if (do_close) begin
      if (!has_text_nxt) begin
        stopped_nxt = 1'b1;
      end else begin
        d.eol  = 1'b1;
        lt_nxt = lt_nxt + 8'd1;
        y_nxt  = y_nxt + line_height;
      end
    end
    if (do_close || in_if.payload.doc_end) begin
      in_tag_nxt   = 1'b0;
      after_sp_nxt = 1'b1;
      pend_sp_nxt  = 1'b0;
      open_nxt     = 1'b0;
      has_text_nxt = 1'b0;
      raw_nxt      = '0;
    end
    if (in_if.payload.doc_end) begin
      d.eod    = 1'b1;
      busy_nxt = 1'b0;
    end
    d.y_e  = y_nxt;
    d.lt_e = lt_nxt;
  end

  assign push      = accept && (d.ch_en || d.eol || d.eod);
  assign push_desc = d;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r     <= 1'b0;
      in_tag_r   <= 1'b0;
      after_sp_r <= 1'b1;
      pend_sp_r  <= 1'b0;
      open_r     <= 1'b0;
      has_text_r <= 1'b0;
      raw_r      <= '0;
      lt_r       <= '0;
      y_r        <= '0;
      stopped_r  <= 1'b0;
    end else if (accept) begin
      busy_r     <= busy_nxt;
      in_tag_r   <= in_tag_nxt;
      after_sp_r <= after_sp_nxt;
      pend_sp_r  <= pend_sp_nxt;
      open_r     <= open_nxt;
      has_text_r <= has_text_nxt;
      raw_r      <= raw_nxt;
      lt_r       <= lt_nxt;
      y_r        <= y_nxt;
      stopped_r  <= stopped_nxt;
    end
  end

endmodule

### src/hlf_queue.sv
// Descriptor queue between the front end and the result sequencer.
// Depends on hlf_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "html_text_line_filter_top_assert.svh"

module hlf_queue #(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  hlf_pkg::desc_t push_desc,
  input  logic           pop,
  output hlf_pkg::desc_t head,
  output logic           empty,
  output logic           full
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  hlf_pkg::desc_t   mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign empty = (cnt_r == '0);
  assign full  = (cnt_r == CNT_FULL);
  assign head  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  `HLF_ASSERT_NOW(a_no_push_full, push, !full || pop, "Queue written while full.")
  `HLF_ASSERT_NOW(a_no_pop_empty, pop, !empty, "Queue read while empty.")
  `HLF_ASSERT_NOW(a_cnt_range, 1'b1, cnt_r <= CNT_FULL, "Queue count out of range.")

endmodule

### src/hlf_back.sv
// Result sequencer: expands each descriptor into one to four result
// transactions behind an output register. Depends on hlf_pkg, hlf_out_if.
`timescale 1ns / 1ps
`include "html_text_line_filter_top_assert.svh"

module hlf_back (
  input  logic           clk,
  input  logic           rst_n,
  input  hlf_pkg::desc_t head,
  input  logic           q_empty,
  output logic           pop,
  hlf_out_if.source      out_if
);

  hlf_pkg::desc_t        cur_r, cur_nxt;
  hlf_pkg::desc_t        src;
  hlf_pkg::desc_t        rest;
  hlf_pkg::out_payload_t res;
  hlf_pkg::out_payload_t out_r, out_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  cur_any;
  logic                  src_valid;
  logic                  load;

  assign cur_any   = cur_r.ch_en || cur_r.eol || cur_r.eod;
  assign src       = cur_any ? cur_r : head;
  assign src_valid = cur_any || !q_empty;
  assign load      = src_valid && (!out_valid_r || out_if.ready);
  assign pop       = load && !cur_any;

  always_comb begin
    rest         = src;
    res.kind     = hlf_pkg::KIND_CHAR;
    res.char_out = '0;
    res.line_y   = src.y_a;
    res.lines_done = src.lt_a;
    res.run_last = 1'b0;
    if (src.sp) begin
      res.char_out = hlf_pkg::CH_SP;
      rest.sp      = 1'b0;
    end else if (src.ch_en) begin
      res.char_out = src.ch;
      rest.ch_en   = 1'b0;
    end else if (src.eol) begin
      res.kind       = hlf_pkg::KIND_EOL;
      res.lines_done = src.lt_a + 8'd1;
      rest.eol       = 1'b0;
    end else begin
      res.kind       = hlf_pkg::KIND_EOD;
      res.line_y     = src.y_e;
      res.lines_done = src.lt_e;
      rest.eod       = 1'b0;
    end
    res.run_last = !(rest.ch_en || rest.eol || rest.eod);
  end

  always_comb begin
    cur_nxt       = cur_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    if (load) begin
      cur_nxt       = rest;
      out_nxt       = res;
      out_valid_nxt = 1'b1;
    end else if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      cur_r       <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      cur_r       <= cur_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_if.valid   = out_valid_r;
  assign out_if.payload = out_r;

  `HLF_ASSERT_NOW(a_leftover_shown, cur_any, out_valid_r,
    "Leftover results held without a result on the output.")
  `HLF_ASSERT_NOW(a_eod_last, out_valid_r && (out_r.kind == hlf_pkg::KIND_EOD),
    out_r.run_last, "Document end result is not the last of its run.")
  `HLF_ASSERT_NEXT(a_leftover_order, load && !cur_any && (rest.ch_en || rest.eol || rest.eod),
    cur_any && !pop, "Leftover results of a descriptor were not kept in order.")

endmodule

### src/html_text_line_filter_top.sv
// Text line filter: strips tags, collapses whitespace and emits characters
// with their line coordinates. One input byte is accepted per cycle while the
// four-entry descriptor queue has room; a byte that causes more than one result
// occupies the output with each of them in turn, and the queue absorbs those
// bursts. A result passes through the descriptor queue and the output register.
// Registers sit on an APB-style port at byte addresses 0 (max_lines),
// 4 (y_start) and 8 (line_height).
`timescale 1ns / 1ps

module html_text_line_filter_top #(
  parameter int LINE_BUFFER = 96,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  hlf_in_if.sink      in_if,
  hlf_out_if.source   out_if,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [7:0]         max_lines_r;
  logic [15:0]        y_start_r;
  logic [15:0]        line_height_r;
  logic               cfg_wr;
  hlf_pkg::reg_idx_t  cfg_idx;
  logic               q_push;
  logic               q_pop;
  logic               q_empty;
  logic               q_full;
  hlf_pkg::desc_t     q_in;
  hlf_pkg::desc_t     q_head;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx    = hlf_pkg::reg_idx_t'(cfg_paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_lines_r   <= 8'd8;
      y_start_r     <= 16'd0;
      line_height_r <= 16'd16;
    end else if (cfg_wr) begin
      case (cfg_idx)
        hlf_pkg::REG_MAX_LINES:   max_lines_r   <= cfg_pwdata[7:0];
        hlf_pkg::REG_Y_START:     y_start_r     <= cfg_pwdata[15:0];
        hlf_pkg::REG_LINE_HEIGHT: line_height_r <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      hlf_pkg::REG_MAX_LINES:   cfg_prdata = {24'd0, max_lines_r};
      hlf_pkg::REG_Y_START:     cfg_prdata = {16'd0, y_start_r};
      hlf_pkg::REG_LINE_HEIGHT: cfg_prdata = {16'd0, line_height_r};
      default:                  cfg_prdata = '0;
    endcase
  end

  hlf_front #(
    .LINE_BUFFER (LINE_BUFFER)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_if       (in_if),
    .max_lines   (max_lines_r),
    .y_start     (y_start_r),
    .line_height (line_height_r),
    .q_full      (q_full),
    .push        (q_push),
    .push_desc   (q_in)
  );

  hlf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_desc (q_in),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty),
    .full      (q_full)
  );

  hlf_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .head    (q_head),
    .q_empty (q_empty),
    .pop     (q_pop),
    .out_if  (out_if)
  );

endmodule

### tb/hlf_line_checker.sv
// Scoreboard for the text line filter: follows byte and result transactions and
// register writes, predicts every result and compares it field by field.
// Depends on hlf_pkg and the channel interfaces in hlf_if.
`timescale 1ns / 1ps

module hlf_line_checker #(
  parameter int LINE_BUFFER = 96
) (
  input  logic        clk,
  input  logic        rst_n,
  hlf_in_if           in_ch,
  hlf_out_if          out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic        cfg_pready,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output int          mismatch_count,
  output int          pending
);

  logic [7:0]   max_lines;
  logic [15:0]  y_start;
  logic [15:0]  line_height;

  logic         in_tag;
  logic         after_space;
  logic         pending_space;
  logic         line_open;
  logic         line_has_text;
  logic         stopped;
  logic         doc_busy;
  logic [6:0]   raw_count;
  logic [7:0]   line_total;
  logic [15:0]  cur_y;

  hlf_pkg::out_payload_t expected_q[$];
  hlf_pkg::out_payload_t burst_q[$];

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("%0t ns: mismatch: %s", $time, msg);
  endtask

  function automatic void push_result(input hlf_pkg::kind_t k, input logic [7:0] ch,
                                      input logic [7:0] done);
    hlf_pkg::out_payload_t r;
    r.kind       = k;
    r.char_out   = ch;
    r.line_y     = cur_y;
    r.lines_done = done;
    r.run_last   = 1'b0;
    burst_q.push_back(r);
  endfunction

  function automatic void clear_line();
    in_tag        = 1'b0;
    after_space   = 1'b1;
    pending_space = 1'b0;
    line_open     = 1'b0;
    line_has_text = 1'b0;
    raw_count     = '0;
  endfunction

  function automatic void close_line();
    if (!line_has_text) begin
      stopped = 1'b1;
    end else begin
      push_result(hlf_pkg::KIND_EOL, hlf_pkg::CH_NUL, line_total + 8'd1);
      line_total = line_total + 8'd1;
      cur_y      = cur_y + line_height;
    end
    clear_line();
  endfunction

  function automatic void filter_byte(input logic [7:0] c, input logic last);
    hlf_pkg::out_payload_t r;
    burst_q.delete();
    if (!doc_busy) begin
      doc_busy   = 1'b1;
      cur_y      = y_start;
      line_total = '0;
      stopped    = 1'b0;
      clear_line();
    end
    if (!stopped && c != hlf_pkg::CH_NUL) begin
      if (c == hlf_pkg::CH_CR || c == hlf_pkg::CH_LF) begin
        if (line_open) begin
          close_line();
        end
      end else begin
        if (!line_open) begin
          if (line_total >= max_lines) begin
            stopped = 1'b1;
          end else begin
            clear_line();
            line_open = 1'b1;
          end
        end
        if (line_open) begin
          raw_count = raw_count + 7'd1;
          if (c == hlf_pkg::CH_LT) begin
            in_tag = 1'b1;
          end else if (c == hlf_pkg::CH_GT) begin
            in_tag = 1'b0;
          end else if (!in_tag) begin
            if (c == hlf_pkg::CH_SP || (c >= hlf_pkg::CH_TAB && c <= hlf_pkg::CH_CR)) begin
              if (!after_space) begin
                pending_space = 1'b1;
                after_space   = 1'b1;
              end
            end else begin
              if (pending_space) begin
                push_result(hlf_pkg::KIND_CHAR, hlf_pkg::CH_SP, line_total);
              end
              pending_space = 1'b0;
              push_result(hlf_pkg::KIND_CHAR, c, line_total);
              after_space   = 1'b0;
              line_has_text = 1'b1;
            end
          end
          if (int'(raw_count) >= LINE_BUFFER - 1) begin
            close_line();
          end
        end
      end
    end
    if (last) begin
      if (!stopped && line_open) begin
        close_line();
      end
      push_result(hlf_pkg::KIND_EOD, hlf_pkg::CH_NUL, line_total);
      clear_line();
      doc_busy = 1'b0;
    end
    if (burst_q.size() > 0) begin
      r = burst_q.pop_back();
      r.run_last = 1'b1;
      burst_q.push_back(r);
    end
    foreach (burst_q[i]) begin
      expected_q.push_back(burst_q[i]);
    end
  endfunction

  task automatic check_result(input hlf_pkg::out_payload_t got);
    hlf_pkg::out_payload_t want;
    if (expected_q.size() == 0) begin
      report_mismatch($sformatf("unexpected result kind %0d char %02h",
                                got.kind, got.char_out));
    end else begin
      want = expected_q.pop_front();
      if (got.kind !== want.kind) begin
        report_mismatch($sformatf("kind got %0d want %0d", got.kind, want.kind));
      end
      if (got.char_out !== want.char_out) begin
        report_mismatch($sformatf("char_out got %02h want %02h",
                                  got.char_out, want.char_out));
      end
      if (got.line_y !== want.line_y) begin
        report_mismatch($sformatf("line_y got %04h want %04h", got.line_y, want.line_y));
      end
      if (got.lines_done !== want.lines_done) begin
        report_mismatch($sformatf("lines_done got %0d want %0d",
                                  got.lines_done, want.lines_done));
      end
      if (got.run_last !== want.run_last) begin
        report_mismatch($sformatf("run_last got %b want %b", got.run_last, want.run_last));
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      mismatch_count = 0;
      max_lines      = 8'd8;
      y_start        = 16'd0;
      line_height    = 16'd16;
      clear_line();
      line_total     = '0;
      cur_y          = 16'd0;
      stopped        = 1'b0;
      doc_busy       = 1'b0;
      expected_q.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        check_result(out_ch.payload);
      end
      if (in_ch.valid && in_ch.ready) begin
        filter_byte(in_ch.payload.char_in, in_ch.payload.doc_end);
      end
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (hlf_pkg::reg_idx_t'(cfg_paddr[3:2]))
          hlf_pkg::REG_MAX_LINES: begin
            max_lines = cfg_pwdata[7:0];
          end
          hlf_pkg::REG_Y_START: begin
            y_start = cfg_pwdata[15:0];
          end
          hlf_pkg::REG_LINE_HEIGHT: begin
            line_height = cfg_pwdata[15:0];
          end
          default: begin
          end
        endcase
      end
    end
    pending <= expected_q.size();
  end

endmodule

### tb/tb_html_text_line_filter_top.sv
// Testbench top for the text line filter: clock, reset, register writes and
// byte stimulus with idle and stall phases; checking is done by hlf_line_checker.
// Depends on hlf_pkg, hlf_if and the filter RTL.
`timescale 1ns / 1ps

module tb_html_text_line_filter_top;

  logic        clk;
  logic        rst_n;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [3:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;
  int          mismatch_count;
  int          pending;
  int          send_idle_pct = 0;
  int          stall_pct = 0;

  logic [7:0]  ml_set [5]    = '{8'd255, 8'd1, 8'd3, 8'd2, 8'd0};
  logic [15:0] ys_set [5]    = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFF0, 16'h0000};
  logic [15:0] lh_set [5]    = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 16'h0010};
  int          idle_set [5]  = '{0, 83, 0, 19, 0};
  int          stall_set [5] = '{0, 0, 83, 19, 0};
  int          budget [5]    = '{1, 10, 10, 10, 1};

  hlf_in_if  in_ch ();
  hlf_out_if out_ch ();

  html_text_line_filter_top dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_if       (in_ch),
    .out_if      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  hlf_line_checker line_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_ch          (in_ch),
    .out_ch         (out_ch),
    .cfg_psel       (cfg_psel),
    .cfg_penable    (cfg_penable),
    .cfg_pwrite     (cfg_pwrite),
    .cfg_pready     (cfg_pready),
    .cfg_paddr      (cfg_paddr),
    .cfg_pwdata     (cfg_pwdata),
    .mismatch_count (mismatch_count),
    .pending        (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("html_text_line_filter_top test failed");
    $finish;
  end

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic send_byte(input logic [7:0] c, input logic last);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.payload <= '{char_in: c, doc_end: last};
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic send_text(input string s, input logic last);
    for (int i = 0; i < s.len(); i++) begin
      send_byte(s[i], last && (i == s.len() - 1));
    end
  endtask

  task automatic wait_quiet();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic apb_write(input hlf_pkg::reg_idx_t idx, input logic [31:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_random_doc(input bit force_long, output int sent);
    logic [7:0] doc_q[$];
    int         n_lines;
    int         len;
    int         roll;
    n_lines = force_long ? 1 : $urandom_range(1, 3);
    if (!force_long && $urandom_range(9) == 0) begin
      len = $urandom_range(1, 20);
      repeat (len) begin
        if ($urandom_range(7) == 0) begin
          doc_q.push_back(hlf_pkg::CH_NUL);
        end else begin
          doc_q.push_back(8'($urandom_range(1, 255)));
        end
      end
    end else begin
      for (int ln = 0; ln < n_lines; ln++) begin
        roll = $urandom_range(99);
        if (force_long && ln == 0) begin
          len = 96;
        end else if (roll < 8) begin
          len = 0;
        end else begin
          len = $urandom_range(1, 8);
        end
        if (len == 0) begin
          doc_q.push_back(hlf_pkg::CH_SP);
          doc_q.push_back(hlf_pkg::CH_LT);
          doc_q.push_back("i");
          doc_q.push_back(hlf_pkg::CH_GT);
        end
        for (int k = 0; k < len; k++) begin
          roll = (force_long && ln == 0) ? 0 : $urandom_range(99);
          if (roll < 55) begin
            doc_q.push_back(8'($urandom_range(8'h21, 8'h7E)));
          end else if (roll < 75) begin
            doc_q.push_back((roll < 68) ? hlf_pkg::CH_SP :
                            8'($urandom_range(hlf_pkg::CH_TAB, 8'h0C)));
          end else if (roll < 85) begin
            doc_q.push_back(hlf_pkg::CH_LT);
            repeat ($urandom_range(1, 3)) doc_q.push_back(8'($urandom_range("a", "z")));
            if ($urandom_range(9) != 0) begin
              doc_q.push_back(hlf_pkg::CH_GT);
            end
          end else if (roll < 95) begin
            doc_q.push_back(8'($urandom_range(1, 255)));
          end else begin
            doc_q.push_back(hlf_pkg::CH_NUL);
          end
        end
        if (ln < n_lines - 1 || $urandom_range(1) == 0) begin
          case ($urandom_range(3))
            0: begin
              doc_q.push_back(hlf_pkg::CH_CR);
            end
            1: begin
              doc_q.push_back(hlf_pkg::CH_LF);
            end
            default: begin
              doc_q.push_back(hlf_pkg::CH_CR);
              doc_q.push_back(hlf_pkg::CH_LF);
            end
          endcase
        end
      end
    end
    foreach (doc_q[i]) begin
      send_byte(doc_q[i], i == doc_q.size() - 1);
    end
    sent = doc_q.size();
  endtask

  initial begin
    int sent;
    int total;

    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.payload = '0;
    cfg_psel      = 1'b0;
    cfg_penable   = 1'b0;
    cfg_pwrite    = 1'b0;
    cfg_paddr     = '0;
    cfg_pwdata    = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset register values: extreme bytes, tag, blanks, empty line and stop.
    send_byte(8'h01, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(hlf_pkg::CH_NUL, 1'b0);
    send_byte(hlf_pkg::CH_TAB, 1'b0);
    send_text(" <x>A \r\n<>\nq", 1'b0);
    send_byte("q", 1'b1);
    send_text("j k", 1'b1);
    send_byte(hlf_pkg::CH_NUL, 1'b1);
    send_text("ab\n", 1'b0);
    wait_quiet();
    apb_write(hlf_pkg::REG_MAX_LINES, 32'd1);
    send_text("cd", 1'b1);

    for (int ph = 0; ph < 5; ph++) begin
      wait_quiet();
      apb_write(hlf_pkg::REG_MAX_LINES, {24'd0, ml_set[ph]});
      apb_write(hlf_pkg::REG_Y_START,
                {16'd0, (ph == 2) ? 16'($urandom) : ys_set[ph]});
      apb_write(hlf_pkg::REG_LINE_HEIGHT,
                {16'd0, (ph == 2) ? 16'($urandom) : lh_set[ph]});
      send_idle_pct = idle_set[ph];
      stall_pct     = stall_set[ph];
      total = 0;
      while (total < budget[ph]) begin
        send_random_doc(ph == 0 && total == 0, sent);
        total += sent;
      end
    end

    wait_quiet();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("html_text_line_filter_top test passed");
    end else begin
      $display("html_text_line_filter_top test failed");
    end
    $finish;
  end

endmodule
